// File: rtl/ffma_pkg.sv
package ffma_pkg;

   typedef enum logic [2:0] {
      OP_FMADD  = 3'd0,
      OP_FMSUB  = 3'd1,
      OP_FNMADD = 3'd2,
      OP_FNMSUB = 3'd3,
      OP_FADD   = 3'd4,
      OP_FSUB   = 3'd5,
      OP_FMUL   = 3'd6,
      OP_NONE   = 3'd7
   } op_type;

   localparam int FRAC_BITS    = 23;
   localparam int SIG_BITS     = 24;
   localparam int PROD_BITS    = 48;
   localparam int DROP_DIST    = 47;
   localparam int EXP_W        = 11;   // signed working exponent
   localparam int MAG_W        = 49;   // sum magnitude, one carry bit over the product
   localparam int BIAS_FRAC    = 150;

   typedef struct packed {
      logic                    sgn;
      logic signed [EXP_W-1:0] exp;
      logic [MAG_W-1:0]        mag;
   } term_type;

   function automatic term_type unpack_word(input logic [31:0] w, input logic lift);
      term_type t;
      logic [SIG_BITS-1:0] sig;
      sig   = {(w[30:23] != 8'd0), w[22:0]};
      t.sgn = w[31];
      t.exp = $signed({3'b000, w[30:23]}) - (lift ? EXP_W'(24) : EXP_W'(0));
      t.mag = lift ? {1'b0, sig, 24'd0} : MAG_W'(sig);
      return t;
   endfunction

endpackage

// File: rtl/float_fused_multiply_add.sv
// Channel   Ports                                       Direction
// request   start, busy, req_type, operand_a/b/c         in (busy out)
// response  rsp_valid, rsp_result_word                   out
//
// Five register stages: multiply, align, add, leading-one search, normalize.
// An item enters every cycle; its result is registered in each stage in turn and
// then appears on the response ports.
// busy is always low: the pipeline never stalls because the receiver cannot.
// Synchronous reset clears the valid bits only.
module float_fused_multiply_add (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   input  logic [31:0] req_operand_c,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_word
);

   typedef ffma_pkg::term_type term_type;

   assign busy = 1'b0;

   // ---------------- stage 1: product, unpack addend
   logic [4:0]  vld_ff, vld_in;
   term_type    a1_ff, b1_ff, a1_in, b1_in;
   logic        fused1_ff, fused1_in, zero1_ff, zero1_in;

   always_comb begin
      term_type u, v, c;
      ffma_pkg::op_type op;
      logic [47:0] prod;
      op = ffma_pkg::op_type'(req_type);
      u  = ffma_pkg::unpack_word(req_operand_a, 1'b0);
      v  = ffma_pkg::unpack_word(req_operand_b, 1'b0);
      c  = ffma_pkg::unpack_word(req_operand_c, 1'b1);
      prod      = u.mag[23:0] * v.mag[23:0];
      fused1_in = 1'b0;
      zero1_in  = 1'b0;
      a1_in     = u;
      b1_in     = c;
      unique case (op) inside
         ffma_pkg::OP_FMADD, ffma_pkg::OP_FMSUB, ffma_pkg::OP_FNMADD,
         ffma_pkg::OP_FNMSUB, ffma_pkg::OP_FMUL: begin
            a1_in.sgn = u.sgn ^ v.sgn ^ (op == ffma_pkg::OP_FNMADD || op == ffma_pkg::OP_FNMSUB);
            a1_in.exp = u.exp + v.exp - ffma_pkg::EXP_W'(ffma_pkg::BIAS_FRAC);
            a1_in.mag = {1'b0, prod};
            b1_in.sgn = c.sgn ^ (op == ffma_pkg::OP_FMSUB || op == ffma_pkg::OP_FNMADD);
            fused1_in = 1'b1;
            // fmul: empty addend passes the product through
            if (op == ffma_pkg::OP_FMUL) b1_in.mag = '0;
         end
         ffma_pkg::OP_FADD, ffma_pkg::OP_FSUB: begin
            a1_in = ffma_pkg::unpack_word(req_operand_a, 1'b1);
            b1_in = ffma_pkg::unpack_word(req_operand_b, 1'b1);
            b1_in.sgn = req_operand_b[31] ^ (op == ffma_pkg::OP_FSUB);
         end
         default: zero1_in = 1'b1;
      endcase
   end

   // ---------------- stage 2: order and align
   term_type big2_ff, sml2_ff, big2_in, sml2_in;
   logic     pass2_ff, pass2_in, fused2_ff, zero2_ff;

   always_comb begin
      term_type x, y;
      logic signed [ffma_pkg::EXP_W-1:0] d;
      x = a1_ff; y = b1_ff;
      pass2_in = 1'b0;
      if (b1_ff.mag == '0) begin
         x = a1_ff; pass2_in = 1'b1;
      end else if (a1_ff.mag == '0) begin
         x = b1_ff; pass2_in = 1'b1;
      end else if (a1_ff.exp > b1_ff.exp ||
                   (a1_ff.exp == b1_ff.exp && a1_ff.mag > b1_ff.mag)) begin
         x = a1_ff; y = b1_ff;
      end else begin
         x = b1_ff; y = a1_ff;
      end
      d = x.exp - y.exp;
      big2_in = x;
      sml2_in = y;
      sml2_in.exp = x.exp;
      sml2_in.mag = (d > ffma_pkg::EXP_W'(ffma_pkg::DROP_DIST)) ? '0 : (y.mag >> d[5:0]);
   end

   // ---------------- stage 3: add or subtract
   term_type sum3_ff, sum3_in;
   logic     zero3_ff;

   always_comb begin
      term_type x, y;
      x = big2_ff; y = sml2_ff;
      if (fused2_ff && y.mag > x.mag) begin
         x = sml2_ff; y = big2_ff;
      end
      sum3_in.exp = x.exp;
      sum3_in.mag = (x.sgn != y.sgn) ? x.mag - y.mag : x.mag + y.mag;
      sum3_in.sgn = (sum3_in.mag == '0) ? (x.sgn & y.sgn) : x.sgn;
      if (pass2_ff) sum3_in = big2_ff;
   end

   // ---------------- stage 4: leading one
   term_type t4_ff;
   logic [5:0] hb4_ff, hb4_in;
   logic       nz4_ff, zero4_ff;

   always_comb begin
      hb4_in = '0;
      for (int i = 0; i < ffma_pkg::MAG_W; i++)
         if (sum3_ff.mag[i]) hb4_in = 6'(i);
   end

   // ---------------- stage 5: normalize and pack
   logic [31:0] res_ff, res_in;

   always_comb begin
      logic signed [ffma_pkg::EXP_W-1:0] e;
      logic [ffma_pkg::MAG_W-1:0] m;
      e = t4_ff.exp + $signed({5'd0, hb4_ff}) - ffma_pkg::EXP_W'(ffma_pkg::FRAC_BITS);
      m = '0;
      if (hb4_ff > 6'd23) m = t4_ff.mag >> (hb4_ff - 6'd23);
      else                m = t4_ff.mag << (6'd23 - hb4_ff);
      res_in = {t4_ff.sgn, 31'd0};
      if (nz4_ff && e > 0) res_in = {t4_ff.sgn, e[7:0], m[22:0]};
      if (zero4_ff) res_in = '0;
   end

   assign vld_in = {vld_ff[3:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
      a1_ff     <= a1_in;
      b1_ff     <= b1_in;
      fused1_ff <= fused1_in;
      zero1_ff  <= zero1_in;
      big2_ff   <= big2_in;
      sml2_ff   <= sml2_in;
      pass2_ff  <= pass2_in;
      fused2_ff <= fused1_ff;
      zero2_ff  <= zero1_ff;
      sum3_ff   <= sum3_in;
      zero3_ff  <= zero2_ff;
      t4_ff     <= sum3_ff;
      hb4_ff    <= hb4_in;
      nz4_ff    <= (sum3_ff.mag != '0);
      zero4_ff  <= zero3_ff;
      res_ff    <= res_in;
   end

   assign rsp_valid       = vld_ff[4];
   assign rsp_result_word = res_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##5 rsp_valid) else $error("result lost in pipeline");
   a_no_busy: assert property (@(posedge clock) !busy) else $error("busy raised");
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] && zero4_ff |=> rsp_result_word == 32'd0) else $error("undefined op nonzero");

endmodule

// File: verif/tb_float_fused_multiply_add.sv
module tb_float_fused_multiply_add;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 5;

   typedef struct {
      logic        neg;
      int          scale;
      logic [63:0] sig;
   } num_type;

   typedef struct {
      ffma_pkg::op_type op;
      logic [31:0]      a;
      logic [31:0]      b;
      logic [31:0]      c;
      logic             known;
      logic [31:0]      word;
   } vec_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_type;
   logic [31:0] req_operand_a;
   logic [31:0] req_operand_b;
   logic [31:0] req_operand_c;
   logic        rsp_valid;
   logic [31:0] rsp_result_word;

   logic [31:0] exp_words[4096];
   logic [11:0] wr_ptr = '0;
   logic [11:0] rd_ptr = '0;
   int          mismatches = 0;
   int          tb_errors;
   int          idle_pct;
   vec_type     dir_table[32];
   logic [4:0]  rows;

   float_fused_multiply_add i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_type(req_type),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .req_operand_c(req_operand_c), .rsp_valid(rsp_valid),
      .rsp_result_word(rsp_result_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic num_type split_word(logic [31:0] w, bit lift);
      num_type t;
      t.neg   = w[31];
      t.scale = int'(w[30:23]);
      t.sig   = {40'd0, (w[30:23] != 8'd0), w[22:0]};
      if (lift) begin
         t.sig   = t.sig << 24;
         t.scale = t.scale - 24;
      end
      return t;
   endfunction

   function automatic num_type mul_words(logic [31:0] x, logic [31:0] y);
      num_type u, v, p;
      u = split_word(x, 0);
      v = split_word(y, 0);
      p.sig   = u.sig * v.sig;
      p.scale = u.scale + v.scale - 150;
      p.neg   = u.neg ^ v.neg;
      return p;
   endfunction

   function automatic logic [31:0] pack_trunc(num_type t);
      int          hb;
      int          e;
      logic [63:0] m;
      hb = -1;
      e  = 0;
      m  = '0;
      for (int i = 63; i >= 0; i--) begin
         if (hb < 0 && t.sig[i]) hb = i;
      end
      if (hb >= 0 && t.scale + hb - 23 > 0) begin
         e = t.scale + hb - 23;
         m = (hb > 23) ? (t.sig >> (hb - 23)) : (t.sig << (23 - hb));
      end
      return {t.neg, e[7:0], m[22:0]};
   endfunction

   function automatic num_type sum_terms(num_type x, num_type y, bit fused);
      num_type t, r;
      int      d;
      if (y.sig == 0) return x;
      if (x.sig == 0) return y;
      if (x.scale > y.scale || (x.scale == y.scale && x.sig > y.sig)) begin
         t = x; x = y; y = t;
      end
      d = y.scale - x.scale;
      x.sig   = (d > 47) ? 64'd0 : (x.sig >> d);
      x.scale = y.scale;
      if (fused && x.sig > y.sig) begin
         t = x; x = y; y = t;
      end
      r.sig   = (x.neg != y.neg) ? y.sig - x.sig : y.sig + x.sig;
      r.scale = y.scale;
      r.neg   = (r.sig == 0) ? (x.neg & y.neg) : y.neg;
      return r;
   endfunction

   function automatic logic [31:0] fma_word(ffma_pkg::op_type op, logic [31:0] a,
                                            logic [31:0] b, logic [31:0] c);
      num_type x, y;
      case (op) inside
         ffma_pkg::OP_FMADD, ffma_pkg::OP_FMSUB, ffma_pkg::OP_FNMADD,
         ffma_pkg::OP_FNMSUB: begin
            x = mul_words(a, b);
            y = split_word(c, 1);
            if (op == ffma_pkg::OP_FNMADD || op == ffma_pkg::OP_FNMSUB) x.neg = ~x.neg;
            if (op == ffma_pkg::OP_FMSUB || op == ffma_pkg::OP_FNMADD) y.neg = ~y.neg;
            return pack_trunc(sum_terms(x, y, 1));
         end
         ffma_pkg::OP_FADD, ffma_pkg::OP_FSUB: begin
            x = split_word(a, 1);
            y = split_word(b, 1);
            if (op == ffma_pkg::OP_FSUB) y.neg = ~y.neg;
            return pack_trunc(sum_terms(x, y, 0));
         end
         ffma_pkg::OP_FMUL: return pack_trunc(mul_words(a, b));
         default: return 32'd0;
      endcase
   endfunction

   function automatic logic [31:0] rand_float();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 9))
         0: w[30:23] = 8'd0;
         1: w[30:23] = 8'hFF;
         2: w[22:0]  = 23'd0;
         3: w[30:23] = 8'(127 + $urandom_range(0, 6) - 3);
         default: w[30:23] = 8'($urandom_range(90, 165));
      endcase
      return w;
   endfunction

   task automatic add_row(ffma_pkg::op_type op, logic [31:0] a, logic [31:0] b,
                          logic [31:0] c, logic known, logic [31:0] word);
      vec_type v;
      v.op = op; v.a = a; v.b = b; v.c = c; v.known = known; v.word = word;
      dir_table[rows] = v;
      rows = rows + 5'd1;
   endtask

   // hold one item until accepted, after a random gap
   task automatic send_item(ffma_pkg::op_type op, logic [31:0] a, logic [31:0] b,
                            logic [31:0] c);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_type      <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      req_operand_c <= c;
      do @(posedge clock); while (busy);
   endtask

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         exp_words[wr_ptr] = fma_word(ffma_pkg::op_type'(req_type), req_operand_a,
                                      req_operand_b, req_operand_c);
         wr_ptr = wr_ptr + 12'd1;
      end
      if (!reset && rsp_valid) begin
         if (wr_ptr == rd_ptr) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_result_word);
         end else begin
            if (exp_words[rd_ptr] !== rsp_result_word) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result_word mismatch: expected %h actual %h",
                           exp_words[rd_ptr], rsp_result_word);
            end
            rd_ptr = rd_ptr + 12'd1;
         end
      end
   end

   initial begin
      #2ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      ffma_pkg::op_type op;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_type = ffma_pkg::OP_FMADD;
      req_operand_a = '0;
      req_operand_b = '0;
      req_operand_c = '0;
      tb_errors = 0;
      idle_pct = 0;
      rows = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // known words: unit product, zero passthrough, exact cancellation, unused selector
      add_row(ffma_pkg::OP_FMUL, 32'h3F800000, 32'h3F800000, 32'h0, 1, 32'h3F800000);
      add_row(ffma_pkg::OP_FADD, 32'h3F800000, 32'h0, 32'h0, 1, 32'h3F800000);
      add_row(ffma_pkg::OP_FMADD, 32'h0, 32'h0, 32'h40000000, 1, 32'h40000000);
      add_row(ffma_pkg::OP_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'h0);
      add_row(ffma_pkg::OP_FSUB, 32'hBF800000, 32'hBF800000, 32'h0, 1, 32'h0);
      add_row(ffma_pkg::OP_FADD, 32'hBF800000, 32'h3F800000, 32'h0, 1, 32'h0);
      // extremes and special cases checked by prediction
      add_row(ffma_pkg::OP_FADD, 32'hBF800000, 32'h3F800000, 32'h0, 0, 0);
      add_row(ffma_pkg::OP_FMUL, 32'h7F7FFFFF, 32'h7F7FFFFF, 32'h0, 0, 0);
      add_row(ffma_pkg::OP_FMUL, 32'h00800000, 32'h00800000, 32'h0, 0, 0);
      add_row(ffma_pkg::OP_FMUL, 32'h007FFFFF, 32'h3F800000, 32'h0, 0, 0);
      add_row(ffma_pkg::OP_FMADD, 32'h3F800000, 32'h3F800000, 32'hBF800000, 0, 0);
      add_row(ffma_pkg::OP_FMSUB, 32'h40000000, 32'h40400000, 32'h3F800000, 0, 0);
      add_row(ffma_pkg::OP_FNMADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0);
      add_row(ffma_pkg::OP_FNMSUB, 32'h7F800000, 32'h7FC00000, 32'h00000001, 0, 0);
      add_row(ffma_pkg::OP_FADD, 32'h4B800000, 32'h00800000, 32'h0, 0, 0);
      add_row(ffma_pkg::OP_FSUB, 32'h3F800001, 32'h3F800000, 32'h0, 0, 0);
      add_row(ffma_pkg::OP_FMADD, 32'h5F000000, 32'h3F800000, 32'h00000001, 0, 0);
      add_row(ffma_pkg::OP_FMADD, 32'h3F800000, 32'h3F800000, 32'h7F000000, 0, 0);

      for (int i = 0; i < int'(rows); i++) begin
         if (dir_table[5'(i)].known &&
             fma_word(dir_table[5'(i)].op, dir_table[5'(i)].a, dir_table[5'(i)].b,
                      dir_table[5'(i)].c) !== dir_table[5'(i)].word) begin
            tb_errors++;
            if (tb_errors <= 10) $display("table row %0d disagrees with predictor", i);
         end
         send_item(dir_table[5'(i)].op, dir_table[5'(i)].a, dir_table[5'(i)].b,
                   dir_table[5'(i)].c);
      end

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1) ? 66 : (phase == 3) ? 27 : 0;
         repeat (440) begin
            op = ffma_pkg::op_type'($urandom_range(0, 7));
            send_item(op, rand_float(), rand_float(), rand_float());
         end
      end
      start <= 1'b0;

      fork
         begin
            wait (wr_ptr == rd_ptr);
            repeat (LATENCY + 3) @(posedge clock);
         end
         begin
            repeat (1000) @(posedge clock);
            tb_errors++;
         end
      join_any
      disable fork;
      if (mismatches == 0 && tb_errors == 0 && wr_ptr == rd_ptr) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
